// ===== hdl/bpu_pkg.sv =====
// bpu_pkg: shared types, codes and helpers for the BMP pixel unpacker.
// Used by every module under hdl/ but bpu_checker; depends on nothing.
package bpu_pkg;

  localparam int MAX_WIDTH = 4096;

  localparam int BPP_W   = 6;
  localparam int WIDTH_W = 13;
  localparam int ROW_W   = 15;
  localparam int IDX_W   = 3;

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;
  localparam int CH_ALPHA = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_BPP        = 3'd0,
    REG_WIDTH      = 3'd1,
    REG_RED_MASK   = 3'd2,
    REG_GREEN_MASK = 3'd3,
    REG_BLUE_MASK  = 3'd4,
    REG_ALPHA_MASK = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    CMD_PALETTE = 1'b0,
    CMD_PIXEL   = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DIRECT = 2'd2
  } op_kind_t;

  typedef struct packed {
    logic [BPP_W-1:0]   bpp;
    logic [WIDTH_W-1:0] width;
    logic [ROW_W-1:0]   row_size;
    logic [3:0][31:0]   mask;
    logic [3:0][4:0]    shift;
  } cfg_t;

  typedef struct packed {
    logic     valid;
    op_kind_t kind;
    logic [7:0]  addr;
    logic [31:0] word;
    logic     row_end;
    logic     run_end;
  } op_t;

  typedef struct packed {
    logic        valid;
    logic        direct;
    logic        hit;
    logic [31:0] word;
    logic        row_end;
    logic        run_end;
  } pix_t;

  function automatic logic [4:0] trailing_zeros(input logic [31:0] m);
    logic [31:0] v;
    logic [4:0]  n;
    v = m;
    n = '0;
    if (v[15:0] == 16'h0) begin
      n[4] = 1'b1;
      v = v >> 16;
    end
    if (v[7:0] == 8'h0) begin
      n[3] = 1'b1;
      v = v >> 8;
    end
    if (v[3:0] == 4'h0) begin
      n[2] = 1'b1;
      v = v >> 4;
    end
    if (v[1:0] == 2'h0) begin
      n[1] = 1'b1;
      v = v >> 2;
    end
    if (v[0] == 1'b0) begin
      n[0] = 1'b1;
    end
    if (m == 32'h0) begin
      n = '0;
    end
    return n;
  endfunction

endpackage

// ===== hdl/bpu_config.sv =====
// bpu_config: configuration registers, channel shift precompute, row geometry.
// Depends on bpu_pkg.
module bpu_config (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic [bpu_pkg::IDX_W-1:0]   cfg_index,
  input  logic [31:0]                 cfg_data,
  output bpu_pkg::cfg_t               cfg
);

  logic [bpu_pkg::BPP_W-1:0]   bpp;
  logic [bpu_pkg::WIDTH_W-1:0] width_raw;
  logic [bpu_pkg::WIDTH_W-1:0] width;
  logic [3:0][31:0]            mask;
  logic [3:0][4:0]             shift;
  logic [17:0]                 w18;
  logic [17:0]                 prod;
  logic [17:0]                 rsum;

  always_ff @(posedge clk) begin
    if (rst) begin
      bpp                      <= 6'd8;
      width_raw                <= 13'd1;
      mask[bpu_pkg::CH_RED]    <= 32'h00ff_0000;
      mask[bpu_pkg::CH_GREEN]  <= 32'h0000_ff00;
      mask[bpu_pkg::CH_BLUE]   <= 32'h0000_00ff;
      mask[bpu_pkg::CH_ALPHA]  <= 32'h0000_0000;
      shift[bpu_pkg::CH_RED]   <= 5'd16;
      shift[bpu_pkg::CH_GREEN] <= 5'd8;
      shift[bpu_pkg::CH_BLUE]  <= 5'd0;
      shift[bpu_pkg::CH_ALPHA] <= 5'd0;
    end else if (cfg_valid) begin
      unique case (bpu_pkg::cfg_reg_t'(cfg_index))
        bpu_pkg::REG_BPP: begin
          bpp <= cfg_data[bpu_pkg::BPP_W-1:0];
        end
        bpu_pkg::REG_WIDTH: begin
          width_raw <= cfg_data[bpu_pkg::WIDTH_W-1:0];
        end
        bpu_pkg::REG_RED_MASK: begin
          mask[bpu_pkg::CH_RED]  <= cfg_data;
          shift[bpu_pkg::CH_RED] <= bpu_pkg::trailing_zeros(cfg_data);
        end
        bpu_pkg::REG_GREEN_MASK: begin
          mask[bpu_pkg::CH_GREEN]  <= cfg_data;
          shift[bpu_pkg::CH_GREEN] <= bpu_pkg::trailing_zeros(cfg_data);
        end
        bpu_pkg::REG_BLUE_MASK: begin
          mask[bpu_pkg::CH_BLUE]  <= cfg_data;
          shift[bpu_pkg::CH_BLUE] <= bpu_pkg::trailing_zeros(cfg_data);
        end
        bpu_pkg::REG_ALPHA_MASK: begin
          mask[bpu_pkg::CH_ALPHA]  <= cfg_data;
          shift[bpu_pkg::CH_ALPHA] <= bpu_pkg::trailing_zeros(cfg_data);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (width_raw == '0) begin
      width = 13'd1;
    end else if (32'(width_raw) > bpu_pkg::MAX_WIDTH) begin
      width = 13'(bpu_pkg::MAX_WIDTH);
    end else begin
      width = width_raw;
    end
  end

  // row bytes = ceil(bpp * width / 32) * 4
  assign w18 = 18'(width);
  always_comb begin
    unique case (bpp)
      6'd2:    prod = w18 << 1;
      6'd4:    prod = w18 << 2;
      6'd8:    prod = w18 << 3;
      6'd16:   prod = w18 << 4;
      6'd24:   prod = (w18 << 4) + (w18 << 3);
      6'd32:   prod = w18 << 5;
      default: prod = w18;
    endcase
  end
  assign rsum = prod + 18'd31;

  assign cfg.bpp      = bpp;
  assign cfg.width    = width;
  assign cfg.row_size = {rsum[17:5], 2'b00};
  assign cfg.mask     = mask;
  assign cfg.shift    = shift;

endmodule

// ===== hdl/bpu_unpack.sv =====
// bpu_unpack: input holding register, row/pixel counters and per-pixel sequencer. Issues at most
// one palette write, palette lookup or direct pixel per cycle while adv is high. Depends on bpu_pkg.
module bpu_unpack (
  input  logic            clk,
  input  logic            rst,
  input  bpu_pkg::cfg_t   cfg,
  input  logic            adv,
  input  logic            s_valid,
  output logic            s_ready,
  input  logic            s_cmd,
  input  logic [7:0]      s_slot,
  input  logic [31:0]     s_word,
  input  logic [7:0]      s_byte,
  output bpu_pkg::op_t    op
);

  logic        hold_valid;
  logic        hold_cmd;
  logic [7:0]  hold_slot;
  logic [31:0] hold_word;
  logic [7:0]  sh;
  logic [2:0]  k;

  logic [bpu_pkg::ROW_W-1:0]   row_pos, row_pos_next;
  logic [bpu_pkg::WIDTH_W-1:0] column, column_next;
  logic [23:0]                 gather, gather_next;
  logic [1:0]                  bip, bip_next;

  logic       indexed, direct;
  logic [2:0] per_m1;
  logic [1:0] size_m1;
  logic [7:0] idx;
  logic [7:0] sh_next;
  logic       col_ok, col_last, last_pix, step, step_last, accept;
  logic [31:0] dword;

  assign indexed = (cfg.bpp == 6'd1) || (cfg.bpp == 6'd2) ||
                   (cfg.bpp == 6'd4) || (cfg.bpp == 6'd8);
  assign direct  = (cfg.bpp == 6'd16) || (cfg.bpp == 6'd24) || (cfg.bpp == 6'd32);

  always_comb begin
    unique case (cfg.bpp)
      6'd1: begin
        per_m1 = 3'd7; idx = {7'b0, sh[7]};   sh_next = sh << 1;
      end
      6'd2: begin
        per_m1 = 3'd3; idx = {6'b0, sh[7:6]}; sh_next = sh << 2;
      end
      6'd4: begin
        per_m1 = 3'd1; idx = {4'b0, sh[7:4]}; sh_next = sh << 4;
      end
      default: begin
        per_m1 = 3'd0; idx = sh;              sh_next = sh;
      end
    endcase
    unique case (cfg.bpp)
      6'd16:   size_m1 = 2'd1;
      6'd24:   size_m1 = 2'd2;
      default: size_m1 = 2'd3;
    endcase
  end

  assign col_ok   = column < cfg.width;
  assign col_last = (14'(column) + 14'd1) == 14'(cfg.width);
  assign last_pix = (k == per_m1) || col_last;
  assign dword    = {8'h00, gather} | (32'(sh) << {size_m1, 3'b000});

  always_comb begin
    if (hold_cmd == bpu_pkg::CMD_PIXEL && indexed) begin
      step_last = !col_ok || last_pix;
    end else begin
      step_last = 1'b1;
    end
  end

  assign step    = hold_valid && adv;
  assign s_ready = !hold_valid || (adv && step_last);
  assign accept  = s_valid && s_ready;

  always_comb begin
    column_next  = column;
    row_pos_next = row_pos;
    gather_next  = gather;
    bip_next     = bip;
    op.valid     = 1'b0;
    op.kind      = bpu_pkg::OP_WRITE;
    op.addr      = hold_slot;
    op.word      = hold_word;
    op.row_end   = col_last;
    op.run_end   = 1'b1;
    if (step) begin
      if (hold_cmd == bpu_pkg::CMD_PALETTE) begin
        op.valid = 1'b1;
      end else if (indexed || direct) begin
        if (indexed && col_ok) begin
          op.valid    = 1'b1;
          op.kind     = bpu_pkg::OP_LOOKUP;
          op.addr     = idx;
          op.run_end  = last_pix;
          column_next = column + 13'd1;
        end else if (direct && col_ok) begin
          if (bip >= size_m1) begin
            op.valid    = 1'b1;
            op.kind     = bpu_pkg::OP_DIRECT;
            op.word     = dword;
            column_next = column + 13'd1;
            gather_next = '0;
            bip_next    = '0;
          end else begin
            gather_next = gather | (24'(sh) << {bip, 3'b000});
            bip_next    = bip + 2'd1;
          end
        end
        if (step_last) begin
          if (row_pos + 15'd1 >= cfg.row_size) begin
            row_pos_next = '0;
            column_next  = '0;
            gather_next  = '0;
            bip_next     = '0;
          end else begin
            row_pos_next = row_pos + 15'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      row_pos    <= '0;
      column     <= '0;
      gather     <= '0;
      bip        <= '0;
      k          <= '0;
    end else begin
      row_pos <= row_pos_next;
      column  <= column_next;
      gather  <= gather_next;
      bip     <= bip_next;
      if (accept) begin
        hold_valid <= 1'b1;
        k          <= '0;
      end else if (step) begin
        if (step_last) begin
          hold_valid <= 1'b0;
        end else begin
          k <= k + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_cmd  <= s_cmd;
      hold_slot <= s_slot;
      hold_word <= s_word;
      sh        <= s_byte;
    end else if (step && !step_last) begin
      sh <= sh_next;
    end
  end

endmodule

// ===== hdl/bpu_palette.sv =====
// bpu_palette: palette memory (one write or one read per cycle while adv is high, registered read)
// with per-entry valid bits so unwritten entries read as zero. Depends on bpu_pkg.
module bpu_palette #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  bpu_pkg::op_t  op,
  output bpu_pkg::pix_t pix,
  output logic [31:0]   rdata
);

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  logic [31:0]              mem [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] vbits;
  logic [AW-1:0]            a;
  logic                     in_range;
  logic                     wr, rd;

  logic        pix_valid;
  logic        pix_direct;
  logic        pix_hit;
  logic [31:0] pix_word;
  logic        pix_row_end;
  logic        pix_run_end;

  assign a        = op.addr[AW-1:0];
  assign in_range = {24'h0, op.addr} < 32'(PALETTE_DEPTH);
  assign wr       = adv && op.valid && op.kind == bpu_pkg::OP_WRITE && in_range;
  assign rd       = adv && op.valid && op.kind == bpu_pkg::OP_LOOKUP;

  // A write lands at the edge before any later lookup reads, so no forwarding.
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[a] <= op.word;
    end
    if (rd) begin
      rdata <= mem[a];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbits <= '0;
    end else if (wr) begin
      vbits[a] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (adv) begin
      pix_valid <= op.valid && op.kind != bpu_pkg::OP_WRITE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix_direct  <= op.kind == bpu_pkg::OP_DIRECT;
      pix_hit     <= in_range && vbits[a];
      pix_word    <= op.word;
      pix_row_end <= op.row_end;
      pix_run_end <= op.run_end;
    end
  end

  assign pix.valid   = pix_valid;
  assign pix.direct  = pix_direct;
  assign pix.hit     = pix_hit;
  assign pix.word    = pix_word;
  assign pix.row_end = pix_row_end;
  assign pix.run_end = pix_run_end;

endmodule

// ===== hdl/bpu_channel.sv =====
// bpu_channel: channel extraction (palette entry or masked direct word) and the
// output register; drives the pipeline advance. Depends on bpu_pkg.
module bpu_channel (
  input  logic          clk,
  input  logic          rst,
  input  bpu_pkg::cfg_t cfg,
  input  bpu_pkg::pix_t pix,
  input  logic [31:0]   rdata,
  input  logic          m_ready,
  output logic          adv,
  output logic          m_valid,
  output logic [7:0]    red,
  output logic [7:0]    green,
  output logic [7:0]    blue,
  output logic [7:0]    alpha,
  output logic          row_end,
  output logic          run_end
);

  logic [31:0]     entry;
  logic [3:0][7:0] ch;

  assign entry = pix.hit ? rdata : 32'h0;
  assign adv   = !m_valid || m_ready;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ch[i] = 8'((pix.word & cfg.mask[i]) >> cfg.shift[i]);
    end
    if (!pix.direct) begin
      ch[bpu_pkg::CH_RED]   = entry[23:16];
      ch[bpu_pkg::CH_GREEN] = entry[15:8];
      ch[bpu_pkg::CH_BLUE]  = entry[7:0];
      ch[bpu_pkg::CH_ALPHA] = entry[31:24];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && pix.valid) begin
      red     <= ch[bpu_pkg::CH_RED];
      green   <= ch[bpu_pkg::CH_GREEN];
      blue    <= ch[bpu_pkg::CH_BLUE];
      alpha   <= ch[bpu_pkg::CH_ALPHA];
      row_end <= pix.row_end;
      run_end <= pix.run_end;
    end
  end

endmodule

// ===== hdl/bmp_pixel_unpacker.sv =====
// bmp_pixel_unpacker: top level of the BMP pixel-array decoder.
// Instantiates bpu_config, bpu_unpack, bpu_palette and bpu_channel; uses bpu_pkg.
//
// Takes one request per cycle on the slave side (a palette write or one raw
// pixel-array byte) unless the output stalls or a 1, 2 or 4-bit indexed byte,
// which yields up to 8 pixels, is still held for lookup; the single palette read
// port does one lookup a cycle. A pixel reaches the master side through the
// holding register, palette read register and output register; later pixels of
// the same byte follow one per cycle while the output does not stall. The palette
// is cleared at reset by per-entry valid bits, so no clearing pass is needed.
// The user must write configuration only while the block is idle; the block
// does not enforce this, and cfg_ready is always high.
module bmp_pixel_unpacker #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // palette_slot[7:0], palette_word[39:8], data_byte[47:40]
  input  logic        s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  output logic        m_tuser,   // row_end
  output logic        m_tlast,   // run_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  bpu_pkg::cfg_t cfg;
  bpu_pkg::op_t  op;
  bpu_pkg::pix_t pix;
  logic [31:0]   rdata;
  logic          adv;

  assign cfg_ready = 1'b1;

  bpu_config u_config (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bpu_unpack u_unpack (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .adv     (adv),
    .s_valid (s_tvalid),
    .s_ready (s_tready),
    .s_cmd   (s_tuser),
    .s_slot  (s_tdata[7:0]),
    .s_word  (s_tdata[39:8]),
    .s_byte  (s_tdata[47:40]),
    .op      (op)
  );

  bpu_palette #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .op    (op),
    .pix   (pix),
    .rdata (rdata)
  );

  bpu_channel u_channel (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .pix     (pix),
    .rdata   (rdata),
    .m_ready (m_tready),
    .adv     (adv),
    .m_valid (m_tvalid),
    .red     (m_tdata[7:0]),
    .green   (m_tdata[15:8]),
    .blue    (m_tdata[23:16]),
    .alpha   (m_tdata[31:24]),
    .row_end (m_tuser),
    .run_end (m_tlast)
  );

endmodule

// ===== hdl/bpu_checker.sv =====
// bpu_checker: port-level assertions for bmp_pixel_unpacker, attached by bind.
// Depends only on the top level's ports.
module bpu_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast,
  input logic        cfg_ready
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("pixel valid right after reset");

  a_ready_after_reset: assert property (@(posedge clk) rst |=> s_tready)
    else $error("request side not ready right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config channel not ready");

  // last pixel of a row always ends its byte's run
  a_row_end_run: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && m_tuser |-> m_tlast)
    else $error("row end without run end");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled pixel changed");

endmodule

bind bmp_pixel_unpacker bpu_checker u_bpu_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser),
  .m_tlast   (m_tlast),
  .cfg_ready (cfg_ready)
);

// ===== verif/tb.sv =====
// tb: self-checking testbench for bmp_pixel_unpacker (palette and pixel-byte requests in,
// decoded pixels out). Depends on hdl/bpu_pkg.sv and hdl/bmp_pixel_unpacker.sv.
// Checks every pixel against an in-bench decoder under random idling and output stalls.
`timescale 1ns / 100ps

module tb;

  localparam int          SETTLE_CYCLES = 16;
  localparam int          HOLD_CYCLES   = 400;
  localparam logic [31:0] DEF_RED_MASK   = 32'h00FF_0000;
  localparam logic [31:0] DEF_GREEN_MASK = 32'h0000_FF00;
  localparam logic [31:0] DEF_BLUE_MASK  = 32'h0000_00FF;
  localparam logic [31:0] RGB555_RED     = 32'h0000_7C00;
  localparam logic [31:0] RGB555_GREEN   = 32'h0000_03E0;
  localparam logic [31:0] RGB555_BLUE    = 32'h0000_001F;
  localparam logic [31:0] RGB555_ALPHA   = 32'h0000_8000;
  localparam logic [31:0] ALPHA_TOP_BYTE = 32'hFF00_0000;

  typedef struct {
    bpu_pkg::cmd_t cmd;
    logic [7:0]    slot;
    logic [31:0]   word;
    logic [7:0]    data;
  } request_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       row_end;
    logic       run_end;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // palette_slot[7:0], palette_word[39:8], data_byte[47:40]
  logic        s_tuser = 1'b0; // command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  logic        m_tuser;        // row_end
  logic        m_tlast;        // run_end
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // decoder copy of the block state
  logic [31:0] palette_copy [256];
  int unsigned cfg_bpp = 8;
  int unsigned cfg_width = 1;
  logic [31:0] cfg_mask [4];
  int unsigned row_pos = 0;
  int unsigned col_pos = 0;
  logic [31:0] gather = '0;
  int unsigned gather_count = 0;

  pixel_t expected_pixels [$];
  int     mismatches = 0;

  bit idling = 1'b1;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_left = 0;

  bmp_pixel_unpacker i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit depth_supported(input int unsigned bpp);
    return bpp == 1 || bpp == 2 || bpp == 4 || bpp == 8 ||
           bpp == 16 || bpp == 24 || bpp == 32;
  endfunction

  function automatic int unsigned effective_width(input int unsigned w);
    if (w == 0) return 1;
    if (w > bpu_pkg::MAX_WIDTH) return bpu_pkg::MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned row_bytes(input int unsigned bpp, input int unsigned w);
    return ((bpp * effective_width(w) + 31) / 32) * 4;
  endfunction

  function automatic logic [7:0] field_from_mask(input logic [31:0] w, input logic [31:0] m);
    int unsigned n;
    logic [31:0] v;
    n = 0;
    if (m != '0) begin
      while (n < 31 && !m[n]) n++;
    end
    v = (w & m) >> n;
    return v[7:0];
  endfunction

  function automatic logic [31:0] random_mask(input logic [31:0] fallback);
    logic [63:0] run;
    int unsigned lo;
    case ($urandom_range(0, 5))
      0: return '0;
      1: return $urandom();
      2: return '1;
      3: return fallback;
      default: begin
        lo  = $urandom_range(0, 31);
        run = ((64'd1 << $urandom_range(1, 12)) - 64'd1) << lo;
        return run[31:0];
      end
    endcase
  endfunction

  // records a palette write, or works out the pixels a pixel byte yields and advances the row state
  function automatic void unpack_request(input request_t rq);
    int unsigned eff_width, row_len, per_byte, field, shift, idx, pix_bytes;
    logic [31:0] entry, word, b;
    pixel_t px;
    if (rq.cmd == bpu_pkg::CMD_PALETTE) begin
      palette_copy[rq.slot] = rq.word;
      return;
    end
    if (!depth_supported(cfg_bpp)) return;
    eff_width = effective_width(cfg_width);
    row_len   = row_bytes(cfg_bpp, cfg_width);
    b         = {24'h0, rq.data};
    if (cfg_bpp <= 8) begin
      per_byte = 8 / cfg_bpp;
      field    = (1 << cfg_bpp) - 1;
      for (int k = 0; k < per_byte && col_pos < eff_width; k++) begin
        shift = cfg_bpp * (per_byte - 1 - k);
        idx   = (b >> shift) & field;
        entry = palette_copy[idx];
        col_pos++;
        px.red     = entry[23:16];
        px.green   = entry[15:8];
        px.blue    = entry[7:0];
        px.alpha   = entry[31:24];
        px.row_end = (col_pos == eff_width);
        px.run_end = (k == per_byte - 1) || (col_pos == eff_width);
        expected_pixels.insert(expected_pixels.size(), px);
      end
    end else if (col_pos < eff_width) begin
      pix_bytes = cfg_bpp / 8;
      if (gather_count + 1 >= pix_bytes) begin
        word = gather | (b << (8 * (pix_bytes - 1)));
        col_pos++;
        px.red     = field_from_mask(word, cfg_mask[bpu_pkg::CH_RED]);
        px.green   = field_from_mask(word, cfg_mask[bpu_pkg::CH_GREEN]);
        px.blue    = field_from_mask(word, cfg_mask[bpu_pkg::CH_BLUE]);
        px.alpha   = field_from_mask(word, cfg_mask[bpu_pkg::CH_ALPHA]);
        px.row_end = (col_pos == eff_width);
        px.run_end = 1'b1;
        expected_pixels.insert(expected_pixels.size(), px);
        gather = '0;
        gather_count = 0;
      end else begin
        gather = (gather | (b << (8 * gather_count))) & 32'h00FF_FFFF;
        gather_count++;
      end
    end
    row_pos++;
    if (row_pos >= row_len) begin
      row_pos = 0;
      col_pos = 0;
      gather = '0;
      gather_count = 0;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  task automatic send_request(input request_t rq);
    @(negedge clk);
    if (idling && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= rq.cmd;
    s_tdata  <= {rq.data, rq.word, rq.slot};
    do @(posedge clk); while (!s_tready);
    unpack_request(rq);
  endtask

  task automatic send_pixel(input logic [7:0] b);
    request_t rq;
    rq.cmd  = bpu_pkg::CMD_PIXEL;
    rq.slot = 8'($urandom_range(0, 255));
    rq.word = $urandom();
    rq.data = b;
    send_request(rq);
  endtask

  task automatic send_palette(input logic [7:0] slot, input logic [31:0] word);
    request_t rq;
    rq.cmd  = bpu_pkg::CMD_PALETTE;
    rq.slot = slot;
    rq.word = word;
    rq.data = 8'($urandom_range(0, 255));
    send_request(rq);
  endtask

  task automatic cfg_write(input bpu_pkg::cfg_reg_t idx, input logic [31:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bpu_pkg::REG_BPP:        cfg_bpp = 32'(d[5:0]);
      bpu_pkg::REG_WIDTH:      cfg_width = 32'(d[12:0]);
      bpu_pkg::REG_RED_MASK:   cfg_mask[bpu_pkg::CH_RED] = d;
      bpu_pkg::REG_GREEN_MASK: cfg_mask[bpu_pkg::CH_GREEN] = d;
      bpu_pkg::REG_BLUE_MASK:  cfg_mask[bpu_pkg::CH_BLUE] = d;
      bpu_pkg::REG_ALPHA_MASK: cfg_mask[bpu_pkg::CH_ALPHA] = d;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // output side: random stalls plus one long hold on request
  always begin
    @(negedge clk);
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (idling && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 15);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always begin : check_output
    pixel_t got;
    pixel_t want;
    @(posedge clk);
    if (!rst && m_tvalid && m_tready) begin
      got.red     = m_tdata[7:0];
      got.green   = m_tdata[15:8];
      got.blue    = m_tdata[23:16];
      got.alpha   = m_tdata[31:24];
      got.row_end = m_tuser;
      got.run_end = m_tlast;
      #1;
      if (expected_pixels.size() == 0) begin
        report_mismatch("pixel with none expected");
      end else begin
        want = expected_pixels.pop_front();
        check_field("red", got.red, want.red);
        check_field("green", got.green, want.green);
        check_field("blue", got.blue, want.blue);
        check_field("alpha", got.alpha, want.alpha);
        check_field("row_end", 8'(got.row_end), 8'(want.row_end));
        check_field("run_end", 8'(got.run_end), 8'(want.run_end));
      end
    end
  end

  // default config: unwritten palette entry, then padding bytes
  task automatic test_reset_defaults();
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'h55);
    send_pixel(8'hAA);
    wait_idle();
  endtask

  task automatic test_palette_lookup();
    send_palette(8'hFF, 32'hFFFF_FFFF);
    send_palette(8'h00, 32'h8040_2010);
    send_palette(8'h01, 32'h01FE_7F00);
    wait_idle();
    cfg_write(bpu_pkg::REG_WIDTH, 32'd4);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'h01);
    send_pixel(8'h02);
    wait_idle();
  endtask

  // 1-bit pixels with a row that ends inside a byte
  task automatic test_indexed_split();
    cfg_write(bpu_pkg::REG_BPP, 32'd1);
    cfg_write(bpu_pkg::REG_WIDTH, 32'd9);
    send_pixel(8'hA5);
    send_pixel(8'h80);
    send_pixel(8'h3C);
    send_pixel(8'hC3);
    wait_idle();
  endtask

  task automatic test_direct_pixels();
    cfg_write(bpu_pkg::REG_BPP, 32'd16);
    cfg_write(bpu_pkg::REG_WIDTH, 32'd2);
    cfg_write(bpu_pkg::REG_RED_MASK, RGB555_RED);
    cfg_write(bpu_pkg::REG_GREEN_MASK, RGB555_GREEN);
    cfg_write(bpu_pkg::REG_BLUE_MASK, RGB555_BLUE);
    cfg_write(bpu_pkg::REG_ALPHA_MASK, RGB555_ALPHA);
    send_pixel(8'hFF);
    send_pixel(8'hFF);
    send_pixel(8'hE0);
    send_pixel(8'h03);
    wait_idle();
    // all-ones mask, top-bit mask, zero mask
    cfg_write(bpu_pkg::REG_BPP, 32'd32);
    cfg_write(bpu_pkg::REG_WIDTH, 32'd1);
    cfg_write(bpu_pkg::REG_RED_MASK, 32'hFFFF_FFFF);
    cfg_write(bpu_pkg::REG_GREEN_MASK, 32'h8000_0000);
    cfg_write(bpu_pkg::REG_BLUE_MASK, 32'h0);
    cfg_write(bpu_pkg::REG_ALPHA_MASK, ALPHA_TOP_BYTE);
    send_pixel(8'h12);
    send_pixel(8'h34);
    send_pixel(8'h56);
    send_pixel(8'hF8);
    wait_idle();
    cfg_write(bpu_pkg::REG_BPP, 32'd24);
    cfg_write(bpu_pkg::REG_RED_MASK, DEF_RED_MASK);
    cfg_write(bpu_pkg::REG_GREEN_MASK, DEF_GREEN_MASK);
    cfg_write(bpu_pkg::REG_BLUE_MASK, DEF_BLUE_MASK);
    cfg_write(bpu_pkg::REG_ALPHA_MASK, 32'h0);
    send_pixel(8'h01);
    send_pixel(8'h80);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    wait_idle();
  endtask

  task automatic test_unsupported_depth();
    cfg_write(bpu_pkg::REG_BPP, 32'd0);
    send_pixel(8'h77);
    wait_idle();
    cfg_write(bpu_pkg::REG_BPP, 32'd63);
    send_pixel(8'h88);
    wait_idle();
  endtask

  // zero width acts as one pixel, oversize width clamps to the maximum
  task automatic test_width_limits();
    cfg_write(bpu_pkg::REG_BPP, 32'd8);
    cfg_write(bpu_pkg::REG_WIDTH, 32'd0);
    send_pixel(8'h5A);
    wait_idle();
    cfg_write(bpu_pkg::REG_BPP, 32'd32);
    cfg_write(bpu_pkg::REG_WIDTH, 32'd8191);
    send_pixel(8'hC0);
    send_pixel(8'hFF);
    send_pixel(8'h0F);
    send_pixel(8'h01);
    wait_idle();
  endtask

  // long output hold while 1-bit bytes keep coming, so the input backs up
  task automatic test_output_stall();
    cfg_write(bpu_pkg::REG_BPP, 32'd1);
    cfg_write(bpu_pkg::REG_WIDTH, 32'd64);
    send_palette(8'h00, $urandom());
    send_palette(8'h01, $urandom());
    @(posedge clk);
    hold_token++;
    repeat (32) send_pixel(8'($urandom_range(0, 255)));
    wait_idle();
  endtask

  task automatic test_random_rows(input int unsigned target);
    int unsigned sent, depth, width, row_len, nrows, nbytes, entries;
    logic [31:0] d;
    sent = 0;
    while (sent < target) begin
      idling = (sent < target - target / 5);
      if ($urandom_range(0, 11) == 0) begin
        do depth = $urandom_range(0, 63); while (depth_supported(depth));
        d = $urandom();
        d[5:0] = depth[5:0];
        cfg_write(bpu_pkg::REG_BPP, d);
        repeat (4) begin
          send_pixel(8'($urandom_range(0, 255)));
          sent++;
        end
      end else begin
        case ($urandom_range(0, 6))
          0: depth = 1;
          1: depth = 2;
          2: depth = 4;
          3: depth = 8;
          4: depth = 16;
          5: depth = 24;
          default: depth = 32;
        endcase
        case ($urandom_range(0, 19))
          0: width = 0;
          1: width = $urandom_range(bpu_pkg::MAX_WIDTH, 8191);
          2, 3: width = $urandom_range(25, 200);
          default: width = $urandom_range(1, 24);
        endcase
        d = $urandom();
        d[5:0] = depth[5:0];
        cfg_write(bpu_pkg::REG_BPP, d);
        d = $urandom();
        d[12:0] = width[12:0];
        cfg_write(bpu_pkg::REG_WIDTH, d);
        if (depth <= 8) begin
          entries = (depth <= 4) ? (1 << depth) : $urandom_range(4, 16);
          for (int i = 0; i < entries; i++) begin
            send_palette(8'((depth <= 4) ? i : $urandom_range(0, 255)), $urandom());
            sent++;
          end
        end else begin
          if ($urandom_range(0, 1))
            cfg_write(bpu_pkg::REG_RED_MASK, random_mask(DEF_RED_MASK));
          if ($urandom_range(0, 1))
            cfg_write(bpu_pkg::REG_GREEN_MASK, random_mask(DEF_GREEN_MASK));
          if ($urandom_range(0, 1))
            cfg_write(bpu_pkg::REG_BLUE_MASK, random_mask(DEF_BLUE_MASK));
          if ($urandom_range(0, 1))
            cfg_write(bpu_pkg::REG_ALPHA_MASK, random_mask(ALPHA_TOP_BYTE));
        end
        row_len = row_bytes(depth, width);
        nrows = $urandom_range(1, 3);
        if (nrows * row_len > 96) nrows = 1;
        if (row_len > 96 || $urandom_range(0, 5) == 0)
          nbytes = $urandom_range(1, (row_len > 40) ? 40 : row_len);
        else
          nbytes = nrows * row_len;
        repeat (nbytes) begin
          if ($urandom_range(0, 24) == 0) begin
            send_palette(8'($urandom_range(0, 255)), $urandom());
            sent++;
          end
          send_pixel(8'($urandom_range(0, 255)));
          sent++;
        end
      end
      wait_idle();
    end
  endtask

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    foreach (palette_copy[i]) palette_copy[i] = '0;
    cfg_mask[bpu_pkg::CH_RED]   = DEF_RED_MASK;
    cfg_mask[bpu_pkg::CH_GREEN] = DEF_GREEN_MASK;
    cfg_mask[bpu_pkg::CH_BLUE]  = DEF_BLUE_MASK;
    cfg_mask[bpu_pkg::CH_ALPHA] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_palette_lookup();
    test_indexed_split();
    test_direct_pixels();
    test_unsupported_depth();
    test_width_limits();
    test_output_stall();
    test_random_rows(380);
    if (expected_pixels.size() != 0) report_mismatch("pixels still expected at end");
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
